// File: rtl/wsla_pkg.sv
package wsla_pkg;

    localparam logic [63:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;
    localparam logic [8:0]  FNV_PRIME_LOW = 9'h1B3;
    localparam int          FNV_PRIME_SHIFT = 40;
    localparam logic [15:0] WEIGHT_ONE = 16'd256;
    localparam int          ENTRY_WIDTH = 138;
    localparam int          DIV_STEPS = 31;

    localparam logic [1:0] ACT_ADD   = 2'd0;
    localparam logic [1:0] ACT_SOLVE = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    localparam logic [2:0] REG_BOUNDS_X = 3'd0;
    localparam logic [2:0] REG_BOUNDS_Y = 3'd1;
    localparam logic [2:0] REG_BOUNDS_W = 3'd2;
    localparam logic [2:0] REG_BOUNDS_H = 3'd3;
    localparam logic [2:0] REG_DIR      = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUM_RD,
        ST_SUM_ACC,
        ST_FLEX,
        ST_ENT_RD,
        ST_ENT_LOAD,
        ST_DIV,
        ST_SIZE,
        ST_MIX,
        ST_EMIT
    } state_t;

    function automatic logic [63:0] fnv_mix(input logic [63:0] h, input logic [31:0] v);
        logic [63:0] x;
        begin
            x = h ^ {32'd0, v};
            fnv_mix = (x << FNV_PRIME_SHIFT) + x * {55'd0, FNV_PRIME_LOW};
        end
    endfunction

endpackage

// File: rtl/wsla_ram.sv
module wsla_ram
    #(
        parameter int WIDTH = 8,
        parameter int DEPTH = 16,
        parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
    )
    (
        input  logic             clk,
        input  logic             we,
        input  logic [AW-1:0]    waddr,
        input  logic [WIDTH-1:0] wdata,
        input  logic [AW-1:0]    raddr,
        output logic [WIDTH-1:0] rdata
    );

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/weighted_span_layout_allocator_top.sv
// Weighted span layout allocator.
// Input stream (s_*): one beat per command. s_tuser holds the action (add, solve,
// clear); s_tdata holds the entry fields of an add. An add or clear stays in the idle state.
// Output stream (m_*): one beat per placed rectangle during a solve, in insertion
// order; m_tlast marks the final one, which also carries the 64-bit layout hash.
// A solve first reads every entry to sum the weights and main-axis minimum sizes,
// then per entry does one RAM read, one multiply, a division on the shared
// bit-serial divider and a five-field hash on the shared hash multiplier.
// s_tready is low for the whole solve; one command is handled at a time.
// When the receiver stalls, the sequencer holds in its emit step until the
// output register is taken; the output beat stays stable meanwhile.
// Configuration through the APB port must be written only while the block is idle (not enforced).
// Reset clears the entry count, the configuration registers and both streams;
// the entry RAM needs no clearing since only stored entries are ever read.
module weighted_span_layout_allocator_top
    import wsla_pkg::*;
    #(
        parameter int MAX_ENTRIES = 64
    )
    (
        input  logic         clk,
        input  logic         rst_n,
        input  logic         psel,
        input  logic         penable,
        input  logic         pwrite,
        input  logic [4:0]   paddr,
        input  logic [31:0]  pwdata,
        output logic [31:0]  prdata,
        output logic         pready,
        input  logic         s_tvalid,
        output logic         s_tready,
        // widget_id, min_width, max_width, min_height, max_height,
        // preferred_width, preferred_height, weight, zero pad
        input  logic [143:0] s_tdata,
        // action
        input  logic [1:0]   s_tuser,
        output logic         m_tvalid,
        input  logic         m_tready,
        // out_id, pos_x, pos_y, size_w, size_h, layout_hash
        output logic [191:0] m_tdata,
        output logic         m_tlast
    );

    localparam int AW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW  = $clog2(MAX_ENTRIES + 1);
    localparam int TWW = 16 + CW;
    localparam int TMW = 15 + CW;
    localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_ENTRIES);

    state_t state_reg, state_next;

    logic signed [15:0] bx_reg, by_reg;
    logic [14:0]        bw_reg, bh_reg;
    logic               dir_reg;

    logic [CW-1:0]  count_reg, count_next;
    logic [CW-1:0]  idx_reg, idx_next;
    logic [TWW-1:0] tw_reg, tw_next;
    logic [TMW-1:0] tmin_reg, tmin_next;
    logic [14:0]    flex_reg, flex_next;
    logic [30:0]    dvd_reg, dvd_next;
    logic [TWW:0]   rem_reg, rem_next;
    logic [4:0]     div_cnt_reg, div_cnt_next;
    logic [2:0]     mix_cnt_reg, mix_cnt_next;
    logic [63:0]    hash_reg, hash_next;
    logic [31:0]    cursor_reg, cursor_next;
    logic [31:0]    id_reg, id_next;
    logic [14:0]    mn_reg, mn_next, mx_reg, mx_next;
    logic [14:0]    cmn_reg, cmn_next, cmx_reg, cmx_next, pref_reg, pref_next;
    logic [31:0]    px_reg, px_next, py_reg, py_next;
    logic [15:0]    sw_reg, sw_next, sh_reg, sh_next, msz_reg, msz_next;
    logic           mval_reg, mval_next, mlast_reg, mlast_next;
    logic [191:0]   mdata_reg, mdata_next;

    logic                   ram_we;
    logic [AW-1:0]          ram_raddr;
    logic [ENTRY_WIDTH-1:0] ram_rdata;

    logic        s_fire, cfg_wr, slot_free, last_ent;
    logic [15:0] eff_w;
    logic [14:0] r_minw, r_maxw, r_minh, r_maxh, r_prefw, r_prefh;
    logic [TWW:0] trial;
    logic [15:0] mval_sum, msize;
    logic [14:0] chi, csize;
    logic [31:0] mix_val;

    assign pready    = 1'b1;
    assign cfg_wr    = psel & penable & pwrite;
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid & s_tready;
    assign slot_free = !mval_reg || m_tready;
    assign last_ent  = (idx_reg + CW'(1)) == count_reg;

    assign m_tvalid = mval_reg;
    assign m_tdata  = mdata_reg;
    assign m_tlast  = mlast_reg;

    always_comb
    begin
        unique case (paddr[4:2])
            REG_BOUNDS_X: prdata = {{16{bx_reg[15]}}, bx_reg};
            REG_BOUNDS_Y: prdata = {{16{by_reg[15]}}, by_reg};
            REG_BOUNDS_W: prdata = {17'd0, bw_reg};
            REG_BOUNDS_H: prdata = {17'd0, bh_reg};
            REG_DIR:      prdata = {31'd0, dir_reg};
            default:      prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bx_reg  <= '0;
            by_reg  <= '0;
            bw_reg  <= '0;
            bh_reg  <= '0;
            dir_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:2])
                REG_BOUNDS_X: bx_reg  <= pwdata[15:0];
                REG_BOUNDS_Y: by_reg  <= pwdata[15:0];
                REG_BOUNDS_W: bw_reg  <= pwdata[14:0];
                REG_BOUNDS_H: bh_reg  <= pwdata[14:0];
                REG_DIR:      dir_reg <= pwdata[0];
                default:      ;
            endcase
        end
    end

    assign ram_we    = s_fire && (s_tuser == ACT_ADD) && (count_reg < MAX_COUNT);
    assign ram_raddr = idx_reg[AW-1:0];

    wsla_ram #(.WIDTH(ENTRY_WIDTH), .DEPTH(MAX_ENTRIES)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (s_tdata[ENTRY_WIDTH-1:0]),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign r_minw  = ram_rdata[46:32];
    assign r_maxw  = ram_rdata[61:47];
    assign r_minh  = ram_rdata[76:62];
    assign r_maxh  = ram_rdata[91:77];
    assign r_prefw = ram_rdata[106:92];
    assign r_prefh = ram_rdata[121:107];
    assign eff_w   = (ram_rdata[137:122] == 16'd0) ? WEIGHT_ONE : ram_rdata[137:122];

    assign trial    = {rem_reg[TWW-1:0], dvd_reg[30]};
    assign mval_sum = {1'b0, mn_reg} + {1'b0, dvd_reg[14:0]};
    assign msize    = (mval_sum < {1'b0, mn_reg}) ? {1'b0, mn_reg} :
                      ((mval_sum > {1'b0, mx_reg}) ? {1'b0, mx_reg} : mval_sum);
    assign chi      = (cmx_reg < (dir_reg ? bw_reg : bh_reg)) ? cmx_reg :
                      (dir_reg ? bw_reg : bh_reg);
    assign csize    = (pref_reg < cmn_reg) ? cmn_reg :
                      ((pref_reg > chi) ? chi : pref_reg);

    always_comb
    begin
        unique case (mix_cnt_reg)
            3'd0:    mix_val = id_reg;
            3'd1:    mix_val = px_reg;
            3'd2:    mix_val = py_reg;
            3'd3:    mix_val = {16'd0, sw_reg};
            default: mix_val = {16'd0, sh_reg};
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_fire && (s_tuser == ACT_SOLVE) && (count_reg != '0))
                begin
                    state_next = ST_SUM_RD;
                end
            end
            ST_SUM_RD:   state_next = ST_SUM_ACC;
            ST_SUM_ACC:  state_next = last_ent ? ST_FLEX : ST_SUM_RD;
            ST_FLEX:     state_next = ST_ENT_RD;
            ST_ENT_RD:   state_next = ST_ENT_LOAD;
            ST_ENT_LOAD: state_next = ST_DIV;
            ST_DIV:
            begin
                if (div_cnt_reg == 5'(DIV_STEPS - 1))
                begin
                    state_next = ST_SIZE;
                end
            end
            ST_SIZE:     state_next = ST_MIX;
            ST_MIX:
            begin
                if (mix_cnt_reg == 3'd4)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    state_next = last_ent ? ST_IDLE : ST_ENT_RD;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        count_next   = count_reg;
        idx_next     = idx_reg;
        tw_next      = tw_reg;
        tmin_next    = tmin_reg;
        flex_next    = flex_reg;
        dvd_next     = dvd_reg;
        rem_next     = rem_reg;
        div_cnt_next = div_cnt_reg;
        mix_cnt_next = mix_cnt_reg;
        hash_next    = hash_reg;
        cursor_next  = cursor_reg;
        id_next      = id_reg;
        mn_next      = mn_reg;
        mx_next      = mx_reg;
        cmn_next     = cmn_reg;
        cmx_next     = cmx_reg;
        pref_next    = pref_reg;
        px_next      = px_reg;
        py_next      = py_reg;
        sw_next      = sw_reg;
        sh_next      = sh_reg;
        msz_next     = msz_reg;
        mval_next    = mval_reg & ~m_tready;
        mlast_next   = mlast_reg;
        mdata_next   = mdata_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    unique case (s_tuser)
                        ACT_ADD:
                        begin
                            if (count_reg < MAX_COUNT)
                            begin
                                count_next = count_reg + CW'(1);
                            end
                        end
                        ACT_CLEAR: count_next = '0;
                        ACT_SOLVE:
                        begin
                            idx_next    = '0;
                            tw_next     = '0;
                            tmin_next   = '0;
                            hash_next   = FNV_BASIS;
                            cursor_next = dir_reg ? 32'(by_reg) : 32'(bx_reg);
                        end
                        default: ;
                    endcase
                end
            end
            ST_SUM_ACC:
            begin
                tw_next   = tw_reg + TWW'(eff_w);
                tmin_next = tmin_reg + TMW'(dir_reg ? r_minh : r_minw);
                idx_next  = last_ent ? '0 : idx_reg + CW'(1);
            end
            ST_FLEX:
            begin
                flex_next = (tmin_reg >= TMW'(dir_reg ? bh_reg : bw_reg)) ? 15'd0 :
                            15'(TMW'(dir_reg ? bh_reg : bw_reg) - tmin_reg);
            end
            ST_ENT_LOAD:
            begin
                id_next      = ram_rdata[31:0];
                mn_next      = dir_reg ? r_minh : r_minw;
                mx_next      = dir_reg ? r_maxh : r_maxw;
                cmn_next     = dir_reg ? r_minw : r_minh;
                cmx_next     = dir_reg ? r_maxw : r_maxh;
                pref_next    = dir_reg ? r_prefw : r_prefh;
                dvd_next     = 31'(flex_reg) * 31'(eff_w);
                rem_next     = '0;
                div_cnt_next = '0;
            end
            ST_DIV:
            begin
                if (trial >= {1'b0, tw_reg})
                begin
                    rem_next = trial - {1'b0, tw_reg};
                    dvd_next = {dvd_reg[29:0], 1'b1};
                end
                else
                begin
                    rem_next = trial;
                    dvd_next = {dvd_reg[29:0], 1'b0};
                end
                div_cnt_next = div_cnt_reg + 5'd1;
            end
            ST_SIZE:
            begin
                msz_next     = msize;
                px_next      = dir_reg ? 32'(bx_reg) : cursor_reg;
                py_next      = dir_reg ? cursor_reg : 32'(by_reg);
                sw_next      = dir_reg ? {1'b0, csize} : msize;
                sh_next      = dir_reg ? msize : {1'b0, csize};
                mix_cnt_next = '0;
            end
            ST_MIX:
            begin
                hash_next    = fnv_mix(hash_reg, mix_val);
                mix_cnt_next = mix_cnt_reg + 3'd1;
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    mval_next   = 1'b1;
                    mlast_next  = last_ent;
                    mdata_next  = {last_ent ? hash_reg : 64'd0, sh_reg, sw_reg,
                                   py_reg, px_reg, id_reg};
                    cursor_next = cursor_reg + 32'(msz_reg);
                    idx_next    = idx_reg + CW'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
            hash_reg  <= FNV_BASIS;
            mval_reg  <= 1'b0;
            mlast_reg <= 1'b0;
            div_cnt_reg <= '0;
            mix_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            hash_reg  <= hash_next;
            mval_reg  <= mval_next;
            mlast_reg <= mlast_next;
            div_cnt_reg <= div_cnt_next;
            mix_cnt_reg <= mix_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tw_reg     <= tw_next;
        tmin_reg   <= tmin_next;
        flex_reg   <= flex_next;
        dvd_reg    <= dvd_next;
        rem_reg    <= rem_next;
        cursor_reg <= cursor_next;
        id_reg     <= id_next;
        mn_reg     <= mn_next;
        mx_reg     <= mx_next;
        cmn_reg    <= cmn_next;
        cmx_reg    <= cmx_next;
        pref_reg   <= pref_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
        sw_reg     <= sw_next;
        sh_reg     <= sh_next;
        msz_reg    <= msz_next;
        mdata_reg  <= mdata_next;
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_COUNT)
        else $error("entry count beyond capacity");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> tw_reg != '0)
        else $error("divide with zero total weight");

    a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && !slot_free) |=> state_reg == ST_EMIT)
        else $error("emit left while output slot busy");

    a_solve_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> idx_reg < count_reg)
        else $error("entry index beyond count during solve");
`endif

endmodule

// File: tb/weighted_span_layout_allocator_top_test.sv
module weighted_span_layout_allocator_top_test;
    import wsla_pkg::*;

    localparam int CAPACITY = 64;
    localparam int QUIET_LIMIT = 40000;
    localparam logic [63:0] HASH_PRIME = 64'd1099511628211;
    localparam logic [1:0] ACT_NONE = 2'd3;

    typedef struct {
        logic [1:0]  action;
        logic [31:0] id;
        logic [14:0] min_w;
        logic [14:0] max_w;
        logic [14:0] min_h;
        logic [14:0] max_h;
        logic [14:0] pref_w;
        logic [14:0] pref_h;
        logic [15:0] weight;
    } cmd_t;

    typedef struct packed {
        logic [31:0] id;
        logic [31:0] px;
        logic [31:0] py;
        logic [15:0] sw;
        logic [15:0] sh;
        logic        last;
        logic [63:0] hash;
    } rect_t;

    logic         clk;
    logic         rst_n;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [4:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_tvalid;
    logic         s_tready;
    // widget_id, min_width, max_width, min_height, max_height,
    // preferred_width, preferred_height, weight, zero pad
    logic [143:0] s_tdata;
    // action
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    // out_id, pos_x, pos_y, size_w, size_h, layout_hash
    logic [191:0] m_tdata;
    logic         m_tlast;

    cmd_t  cmd_q[$];
    rect_t rect_q[$];
    cmd_t  stored[CAPACITY];
    int    stored_count;
    int    org_x;
    int    org_y;
    int    extent_w;
    int    extent_h;
    bit    vertical;
    int    send_idle;
    int    recv_idle;
    int    mismatches;
    int    cmds_sent;
    int    solves_done;
    int    rects_seen;
    int    quiet_cycles;

    weighted_span_layout_allocator_top dut (.*);

    always #5 clk = ~clk;

    function automatic logic [63:0] hash_step(logic [63:0] h, logic [31:0] v);
        return (h ^ {32'd0, v}) * HASH_PRIME;
    endfunction

    function automatic int fit(int v, int lo, int hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint unsigned share(logic [15:0] w);
        return w == 0 ? longint'(WEIGHT_ONE) : longint'(w);
    endfunction

    task automatic queue_cmd(cmd_t c);
        cmd_q.insert(cmd_q.size(), c);
    endtask

    task automatic place_entries(cmd_t c);
        longint tmin;
        longint flex;
        longint cursor;
        longint unsigned tw;
        logic [63:0] h;
        int mn;
        int mx;
        int cmn;
        int cmx;
        int pref;
        int msize;
        int csize;
        rect_t r;
        case (c.action)
            ACT_ADD:
                if (stored_count < CAPACITY)
                begin
                    stored[stored_count] = c;
                    stored_count++;
                end
            ACT_CLEAR: stored_count = 0;
            ACT_SOLVE:
                if (stored_count > 0)
                begin
                    tmin = 0;
                    tw = 0;
                    for (int i = 0; i < stored_count; i++)
                    begin
                        tmin += longint'(vertical ? stored[i].min_h : stored[i].min_w);
                        tw += share(stored[i].weight);
                    end
                    flex = longint'(vertical ? extent_h : extent_w) - tmin;
                    if (flex < 0)
                        flex = 0;
                    cursor = longint'(vertical ? org_y : org_x);
                    h = FNV_BASIS;
                    solves_done++;
                    for (int i = 0; i < stored_count; i++)
                    begin
                        mn = int'(vertical ? stored[i].min_h : stored[i].min_w);
                        mx = int'(vertical ? stored[i].max_h : stored[i].max_w);
                        cmn = int'(vertical ? stored[i].min_w : stored[i].min_h);
                        cmx = int'(vertical ? stored[i].max_w : stored[i].max_h);
                        pref = int'(vertical ? stored[i].pref_w : stored[i].pref_h);
                        msize = fit(mn + int'((longint'(flex) * share(stored[i].weight)) / tw),
                                    mn, mx);
                        csize = fit(pref, cmn, (vertical ? extent_w : extent_h) < cmx ?
                                    (vertical ? extent_w : extent_h) : cmx);
                        r.id = stored[i].id;
                        r.px = vertical ? org_x : cursor[31:0];
                        r.py = vertical ? cursor[31:0] : org_y;
                        r.sw = vertical ? csize[15:0] : msize[15:0];
                        r.sh = vertical ? msize[15:0] : csize[15:0];
                        cursor += msize;
                        h = hash_step(h, r.id);
                        h = hash_step(h, r.px);
                        h = hash_step(h, r.py);
                        h = hash_step(h, vertical ? csize : msize);
                        h = hash_step(h, vertical ? msize : csize);
                        r.last = (i == stored_count - 1);
                        r.hash = r.last ? h : 64'd0;
                        rect_q.insert(rect_q.size(), r);
                    end
                end
            default: ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                cmds_sent++;
                void'(cmd_q.pop_front());
            end
            if (!s_tvalid || s_tready)
            begin
                if (cmd_q.size() > (s_tvalid && s_tready ? 0 : 0) && cmd_q.size() > 0 &&
                    $urandom_range(99) >= send_idle)
                begin
                    s_tvalid <= 1'b1;
                    s_tuser <= cmd_q[0].action;
                    s_tdata <= {6'd0, cmd_q[0].weight, cmd_q[0].pref_h, cmd_q[0].pref_w,
                                cmd_q[0].max_h, cmd_q[0].min_h, cmd_q[0].max_w,
                                cmd_q[0].min_w, cmd_q[0].id};
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // predict on the beat itself so expectations exist before any result
    always @(posedge clk)
    begin
        cmd_t c;
        if (rst_n && s_tvalid && s_tready)
        begin
            c.action = s_tuser;
            {c.weight, c.pref_h, c.pref_w, c.max_h, c.min_h, c.max_w, c.min_w, c.id} =
                s_tdata[137:0];
            place_entries(c);
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= $urandom_range(99) >= recv_idle;
    end

    always @(posedge clk)
    begin
        rect_t e;
        rect_t a;
        if (rst_n && m_tvalid && m_tready)
        begin
            rects_seen++;
            {a.hash, a.sh, a.sw, a.py, a.px, a.id} = m_tdata;
            a.last = m_tlast;
            if (rect_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: id=%h", a.id);
            end
            else
            begin
                e = rect_q.pop_front();
                if (a != e)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch exp id=%h x=%h y=%h w=%h h=%h l=%b hash=%h",
                                 e.id, e.px, e.py, e.sw, e.sh, e.last, e.hash);
                        $display("         got id=%h x=%h y=%h w=%h h=%h l=%b hash=%h",
                                 a.id, a.px, a.py, a.sw, a.sh, a.last, a.hash);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no beat for %0d cycles", QUIET_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic reg_write(logic [2:0] idx, logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_BOUNDS_X: org_x = int'($signed(value[15:0]));
            REG_BOUNDS_Y: org_y = int'($signed(value[15:0]));
            REG_BOUNDS_W: extent_w = int'(value[14:0]);
            REG_BOUNDS_H: extent_h = int'(value[14:0]);
            default: vertical = value[0];
        endcase
    endtask

    task automatic setup_area(int bx, int by, int bw, int bh, bit dir);
        reg_write(REG_BOUNDS_X, bx);
        reg_write(REG_BOUNDS_Y, by);
        reg_write(REG_BOUNDS_W, bw);
        reg_write(REG_BOUNDS_H, bh);
        reg_write(REG_DIR, 32'(dir));
    endtask

    task automatic settle();
        while (cmd_q.size() > 0 || s_tvalid || rect_q.size() > 0 || !s_tready)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    function automatic cmd_t op(logic [1:0] action);
        cmd_t c;
        c.action = action;
        c.id = $urandom;
        {c.min_w, c.max_w, c.min_h, c.max_h, c.pref_w, c.pref_h} =
            90'({$urandom, $urandom, $urandom});
        c.weight = 16'($urandom);
        return c;
    endfunction

    function automatic cmd_t entry(logic [31:0] id, int mnw, int mxw, int mnh, int mxh,
                                   int pw, int ph, int w);
        cmd_t c;
        c.action = ACT_ADD;
        c.id = id;
        c.min_w = 15'(mnw);
        c.max_w = 15'(mxw);
        c.min_h = 15'(mnh);
        c.max_h = 15'(mxh);
        c.pref_w = 15'(pw);
        c.pref_h = 15'(ph);
        c.weight = 16'(w);
        return c;
    endfunction

    function automatic cmd_t random_entry();
        cmd_t c;
        int a;
        int b;
        c = op(ACT_ADD);
        if ($urandom_range(3) != 0)
        begin
            a = $urandom_range(300);
            b = $urandom_range(300);
            c.min_w = 15'(a < b ? a : b);
            c.max_w = 15'($urandom_range(9) == 0 ? (a < b ? a : b) / 2 : (a < b ? b : a));
            a = $urandom_range(300);
            b = $urandom_range(300);
            c.min_h = 15'(a < b ? a : b);
            c.max_h = 15'(a < b ? b : a);
            c.pref_w = 15'($urandom_range(400));
            c.pref_h = 15'($urandom_range(400));
        end
        if ($urandom_range(4) == 0)
            c.weight = 0;
        else if ($urandom_range(1) == 0)
            c.weight = 16'($urandom_range(1024));
        return c;
    endfunction

    initial
    begin
        int n;
        int sections;
        bit filled;
        clk = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        send_idle = 23;
        recv_idle = 85;
        mismatches = 0;
        cmds_sent = 0;
        solves_done = 0;
        rects_seen = 0;
        quiet_cycles = 0;
        stored_count = 0;
        org_x = 0;
        org_y = 0;
        extent_w = 0;
        extent_h = 0;
        vertical = 0;
        sections = 0;
        filled = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        setup_area(-5, 7, 200, 100, 1'b0);
        queue_cmd(op(ACT_SOLVE));
        queue_cmd(op(ACT_NONE));
        queue_cmd(op(ACT_CLEAR));
        queue_cmd(op(ACT_SOLVE));
        queue_cmd(entry(32'hFFFF_FFFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF,
                        15'h7FFF, 15'h7FFF, 16'hFFFF));
        queue_cmd(entry(32'h0, 0, 0, 0, 0, 0, 0, 0));
        queue_cmd(entry(32'h1234_5678, 50, 20, 40, 10, 5, 60, 16'h0100));
        queue_cmd(entry(32'hA5A5_5A5A, 10, 90, 5, 200, 300, 80, 16'h0080));
        queue_cmd(op(ACT_SOLVE));
        queue_cmd(op(ACT_CLEAR));
        queue_cmd(entry(32'h0000_0001, 30, 400, 2, 50, 60, 1, 0));
        queue_cmd(entry(32'h8000_0000, 25, 70, 3, 8, 4, 20, 16'h0300));
        queue_cmd(entry(32'h5555_AAAA, 100, 100, 0, 32767, 32767, 32767, 1));
        queue_cmd(op(ACT_SOLVE));
        settle();
        setup_area(32767, -32768, 80, 32767, 1'b1);
        queue_cmd(op(ACT_SOLVE));
        queue_cmd(op(ACT_CLEAR));
        queue_cmd(entry(32'h0BAD_F00D, 7, 9, 90, 20, 12, 3, 0));
        queue_cmd(op(ACT_SOLVE));
        settle();

        while (cmds_sent < 230)
        begin
            if (cmds_sent >= 154)
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            else if (cmds_sent >= 77)
            begin
                send_idle = 85;
                recv_idle = 23;
            end
            case (sections % 4)
                0: setup_area(-32768, 32767, 0, 0, sections[2]);
                1: setup_area(32767, -32768, 32767, 32767, !sections[2]);
                default: setup_area($urandom, $urandom, $urandom_range(2000),
                                    $urandom_range(2000), 1'($urandom));
            endcase
            for (int s = 0; s < 3; s++)
            begin
                if ($urandom_range(2) == 0)
                    queue_cmd(op(ACT_CLEAR));
                if (!filled && cmds_sent > 100)
                begin
                    filled = 1;
                    n = CAPACITY + 2;
                    queue_cmd(op(ACT_CLEAR));
                end
                else
                    n = $urandom_range(1, 8);
                for (int i = 0; i < n; i++)
                    queue_cmd(random_entry());
                if ($urandom_range(5) == 0)
                    queue_cmd(op($urandom_range(9) < 5 ? ACT_NONE : ACT_ADD));
                queue_cmd(op(ACT_SOLVE));
                if ($urandom_range(4) == 0)
                    queue_cmd(op(ACT_SOLVE));
            end
            settle();
            sections++;
        end

        settle();
        $display("%0d commands, %0d solves, %0d rectangles checked across %0d area settings",
                 cmds_sent, solves_done, rects_seen, sections + 2);
        $display("both directions, empty and full lists, zero weights, inverted limits covered");
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
